FILE: rtl/core/tmrle_pkg.sv
// Shared types and constants for the tile map run-length decoder.
`timescale 1ns / 1ps

package tmrle_pkg;

    // Largest map height the row counter has to reach
    localparam int MAX_ROWS = 64;
    localparam int ROW_W    = $clog2(MAX_ROWS + 1);

    // Command queue between the front and back parts
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = CFG_INDEX_W'(1);

    localparam logic [11:0] COLUMN_COUNT_RST = 12'd400;
    localparam logic [6:0]  ROW_COUNT_RST    = 7'd18;

    // Stream word classes
    localparam logic [1:0] KIND_TOKEN    = 2'd0;
    localparam logic [1:0] KIND_LITERAL  = 2'd1;
    localparam logic [1:0] KIND_RUN_TILE = 2'd2;

    // Input item
    typedef struct packed {
        logic [15:0] stream_word;
        logic        new_map;
    } word_item_t;

    // Result item
    typedef struct packed {
        logic [15:0] tile_word;
        logic [5:0]  map_row;
        logic [15:0] first_column;
        logic [14:0] cell_count;
        logic        overshoot;
        logic        map_done;
    } fill_item_t;

    // Command from the classifier to the fill engine
    typedef struct packed {
        logic        clear;
        logic        fill;
        logic [15:0] tile;
        logic [14:0] cells;
        logic        last;
    } fill_cmd_t;

endpackage

FILE: rtl/core/tmrle_front.sv
// Front part: accepts stream words and turns them into fill commands.
`timescale 1ns / 1ps

module tmrle_front
    import tmrle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  word_item_t word,
    output logic       push,
    output fill_cmd_t  cmd
);

    logic [1:0]  kind_reg, kind_next;
    logic [14:0] cells_left_reg, cells_left_next;
    logic [14:0] run_length_reg, run_length_next;

    logic [1:0]  kind_cur;
    logic [14:0] cells_left_cur;
    logic [14:0] run_length_cur;
    logic [14:0] cells_dec;
    logic        fill;
    logic [14:0] cells;
    logic        last;

    // Start from cleared state when the word opens a new map
    assign kind_cur       = word.new_map ? KIND_TOKEN : kind_reg;
    assign cells_left_cur = word.new_map ? 15'd0 : cells_left_reg;
    assign run_length_cur = word.new_map ? 15'd0 : run_length_reg;
    assign cells_dec      = cells_left_cur - 15'd1;

    // Classify the word against the current token state
    always_comb
    begin
        kind_next       = kind_cur;
        cells_left_next = cells_left_cur;
        run_length_next = run_length_cur;
        fill            = 1'b0;
        cells           = 15'd1;
        last            = 1'b0;
        unique case (kind_cur)
            KIND_TOKEN:
            begin
                if (word.stream_word[15])
                begin
                    run_length_next = word.stream_word[14:0];
                    kind_next       = KIND_RUN_TILE;
                end
                else if (word.stream_word != 16'd0)
                begin
                    cells_left_next = word.stream_word[14:0];
                    kind_next       = KIND_LITERAL;
                end
            end
            KIND_LITERAL:
            begin
                cells_left_next = cells_dec;
                fill            = 1'b1;
                last            = (cells_dec == 15'd0);
                kind_next       = (cells_dec == 15'd0) ? KIND_TOKEN : KIND_LITERAL;
            end
            KIND_RUN_TILE:
            begin
                kind_next = KIND_TOKEN;
                fill      = (run_length_cur != 15'd0);
                cells     = run_length_cur;
                last      = 1'b1;
            end
            default:
            begin
                kind_next = KIND_TOKEN;
            end
        endcase
    end

    assign cmd.clear = word.new_map;
    assign cmd.fill  = fill;
    assign cmd.tile  = word.stream_word;
    assign cmd.cells = cells;
    assign cmd.last  = last;

    // Forward only words that fill cells or clear the map
    assign push = accept && (fill || word.new_map);

    // Advance token state on every accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg       <= KIND_TOKEN;
            cells_left_reg <= 15'd0;
            run_length_reg <= 15'd0;
        end
        else if (accept)
        begin
            kind_reg       <= kind_next;
            cells_left_reg <= cells_left_next;
            run_length_reg <= run_length_next;
        end
    end

endmodule

FILE: rtl/core/tmrle_queue.sv
// Short command queue between the classifier and the fill engine.
`timescale 1ns / 1ps

module tmrle_queue
    import tmrle_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  fill_cmd_t push_cmd,
    output logic      not_full,
    input  logic      pop,
    output logic      not_empty,
    output fill_cmd_t head
);

    fill_cmd_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign not_full  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != QCNT_W'(0));
    assign head      = entry_reg[rd_ptr_reg];

    // Wrap pointers at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? QPTR_W'(0)
                                                                   : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? QPTR_W'(0)
                                                                   : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef SYNTH
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> not_full)
        else $error("queue pushed while full");
    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue popped while empty");
`endif

endmodule

FILE: rtl/core/tmrle_back.sv
// Back part: tracks column budget and rows, and issues fill items.
`timescale 1ns / 1ps

module tmrle_back
    import tmrle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [11:0] column_count,
    input  logic [6:0]  row_count,
    input  logic        cmd_valid,
    input  fill_cmd_t   cmd,
    output logic        pop,
    output logic        fill_valid,
    input  logic        fill_ready,
    output fill_item_t  fill
);

    logic [15:0]      budget_reg, budget_next;
    logic [15:0]      column_reg, column_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             finished_reg, finished_next;
    logic             out_valid_reg, out_valid_next;
    fill_item_t       out_reg;
    fill_item_t       out_next;

    logic [15:0]      budget_cur;
    logic [15:0]      column_cur;
    logic [ROW_W-1:0] row_cur;
    logic             finished_cur;
    logic             produce;
    logic [15:0]      cells_w;
    logic [16:0]      budget_diff;
    logic [15:0]      budget_after;
    logic [15:0]      column_after;
    logic [ROW_W-1:0] row_inc;
    logic [ROW_W-1:0] rows_limit;
    logic             row_end;
    logic             done;

    // Take a command when the output register is free or being drained
    assign pop = cmd_valid && (!out_valid_reg || fill_ready);

    // Clamp row_count into one to MAX_ROWS
    always_comb
    begin
        priority if (row_count == 7'd0)
        begin
            rows_limit = ROW_W'(1);
        end
        else if (32'(row_count) > 32'(MAX_ROWS))
        begin
            rows_limit = ROW_W'(MAX_ROWS);
        end
        else
        begin
            rows_limit = ROW_W'(row_count);
        end
    end

    // Apply a new map clear ahead of the fill
    assign budget_cur   = cmd.clear ? {4'd0, column_count} : budget_reg;
    assign column_cur   = cmd.clear ? 16'd0 : column_reg;
    assign row_cur      = cmd.clear ? ROW_W'(0) : row_reg;
    assign finished_cur = cmd.clear ? 1'b0 : finished_reg;

    // Budget, column and row arithmetic for one fill
    assign produce      = cmd.fill && !finished_cur;
    assign cells_w      = {1'b0, cmd.cells};
    assign budget_diff  = {budget_cur[15], budget_cur} - {1'b0, cells_w};
    assign budget_after = budget_cur - cells_w;
    assign column_after = column_cur + cells_w;
    assign row_inc      = row_cur + ROW_W'(1);
    assign row_end      = produce && cmd.last && (budget_after == 16'd0);
    assign done         = row_end && (row_inc >= rows_limit);

    always_comb
    begin
        budget_next   = budget_cur;
        column_next   = column_cur;
        row_next      = row_cur;
        finished_next = finished_cur;
        if (produce)
        begin
            budget_next   = row_end ? {4'd0, column_count} : budget_after;
            column_next   = row_end ? 16'd0 : column_after;
            row_next      = row_end ? row_inc : row_cur;
            finished_next = done;
        end
    end

    // Build the result item
    always_comb
    begin
        out_next.tile_word    = cmd.tile;
        out_next.map_row      = row_cur[5:0];
        out_next.first_column = column_cur;
        out_next.cell_count   = cmd.cells;
        out_next.overshoot    = budget_diff[16];
        out_next.map_done     = done;
    end

    // Hold the result until taken, load a new one when produced
    always_comb
    begin
        out_valid_next = out_valid_reg && !fill_ready;
        if (pop && produce)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg    <= {4'd0, COLUMN_COUNT_RST};
            column_reg    <= 16'd0;
            row_reg       <= '0;
            finished_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                budget_reg   <= budget_next;
                column_reg   <= column_next;
                row_reg      <= row_next;
                finished_reg <= finished_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && produce)
        begin
            out_reg <= out_next;
        end
    end

    assign fill_valid = out_valid_reg;
    assign fill       = out_reg;

`ifndef SYNTH
    a_result_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(pop))
        else $error("result appeared without a command");
    a_done_sets_finished: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && produce && done) |=> finished_reg)
        else $error("map done did not stop the decoder");
    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !finished_reg |-> (32'(row_reg) < 32'(MAX_ROWS)))
        else $error("row position past the map while decoding");
`endif

endmodule

FILE: rtl/core/tile_map_rle_decoder.sv
// Top level of the tile map run-length decoder.
`timescale 1ns / 1ps
//
//  channel  direction  handshake                payload
//  word     in         word_valid / word_ready  word_item_t: stream_word, new_map
//  fill     out        fill_valid / fill_ready  fill_item_t: tile, row, column, cells, flags
//  cfg      in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
//  One word is taken per cycle while the queue has room; its fill goes through the queue, then out_reg.
//  The rate is set by the fill engine: one queued command per cycle unless fill output stalls.
//  Reset loads column_count 400 and row_count 18 and clears all decoder state.
//  A stalled fill output backs up the two-entry command queue, then word_ready drops.
//  cfg_ready is always high; writes take effect at the next budget load or row end.

module tile_map_rle_decoder
    import tmrle_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   word_valid,
    output logic                   word_ready,
    input  word_item_t             word,
    output logic                   fill_valid,
    input  logic                   fill_ready,
    output fill_item_t             fill,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [11:0] column_count_reg;
    logic [6:0]  row_count_reg;
    logic        word_accept;
    logic        push;
    fill_cmd_t   push_cmd;
    logic        queue_not_full;
    logic        queue_not_empty;
    logic        pop;
    fill_cmd_t   head_cmd;

    assign cfg_ready   = 1'b1;
    assign word_ready  = queue_not_full;
    assign word_accept = word_valid && word_ready;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= COLUMN_COUNT_RST;
            row_count_reg    <= ROW_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_COLUMN_COUNT)
            begin
                column_count_reg <= cfg_data[11:0];
            end
            else if (cfg_index == REG_ROW_COUNT)
            begin
                row_count_reg <= cfg_data[6:0];
            end
        end
    end

    tmrle_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (word_accept),
        .word   (word),
        .push   (push),
        .cmd    (push_cmd)
    );

    tmrle_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .not_full  (queue_not_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .head      (head_cmd)
    );

    tmrle_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .column_count (column_count_reg),
        .row_count    (row_count_reg),
        .cmd_valid    (queue_not_empty),
        .cmd          (head_cmd),
        .pop          (pop),
        .fill_valid   (fill_valid),
        .fill_ready   (fill_ready),
        .fill         (fill)
    );

endmodule

FILE: bench/tb_tile_map_rle_decoder.sv
// Self-checking testbench for the tile map run-length decoder.
`timescale 1ns / 1ps

module tb_tile_map_rle_decoder
    import tmrle_pkg::*;
;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 8;

    // Predicts fill items from accepted stream words and checks the block's output
    class fill_predictor;
        logic [11:0]      column_count;
        logic [6:0]       row_count;
        logic [1:0]       word_kind;
        logic [14:0]      cells_left;
        logic [15:0]      column_budget;
        logic [15:0]      column_position;
        logic [ROW_W-1:0] row_position;
        logic [14:0]      run_length;
        bit               finished;
        fill_item_t       pending_fills[$];
        int               errors;

        function new();
            column_count = COLUMN_COUNT_RST;
            row_count    = ROW_COUNT_RST;
            errors       = 0;
            start_map();
        endfunction

        function void start_map();
            word_kind       = KIND_TOKEN;
            cells_left      = '0;
            column_budget   = 16'(column_count);
            column_position = '0;
            row_position    = '0;
            run_length      = '0;
            finished        = 1'b0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            if (index == REG_COLUMN_COUNT)
                column_count = data[11:0];
            else if (index == REG_ROW_COUNT)
                row_count = data[6:0];
        endfunction

        // Work out one fill; test the row end only when it closes a token
        function void add_fill(logic [15:0] tile, logic [14:0] cells, bit closes_token);
            fill_item_t f;
            int         rows;
            f.tile_word    = tile;
            f.map_row      = row_position[5:0];
            f.first_column = column_position;
            f.cell_count   = cells;
            f.overshoot    = (int'($signed(column_budget)) - int'(cells)) < 0;
            f.map_done     = 1'b0;
            column_budget   = column_budget - 16'(cells);
            column_position = column_position + 16'(cells);
            if (closes_token && column_budget == 16'd0) begin
                rows = int'(row_count);
                if (rows == 0)
                    rows = 1;
                if (rows > MAX_ROWS)
                    rows = MAX_ROWS;
                row_position    = row_position + 1'b1;
                column_budget   = 16'(column_count);
                column_position = '0;
                if (int'(row_position) >= rows) begin
                    finished   = 1'b1;
                    f.map_done = 1'b1;
                end
            end
            pending_fills.push_back(f);
        endfunction

        // Note an accepted stream word; return 0 if the block ignores it
        function bit take_word(word_item_t w);
            if (w.new_map)
                start_map();
            if (finished)
                return 1'b0;
            case (word_kind)
                KIND_TOKEN:
                begin
                    if (w.stream_word[15]) begin
                        run_length = w.stream_word[14:0];
                        word_kind  = KIND_RUN_TILE;
                    end
                    else if (w.stream_word != 16'd0) begin
                        cells_left = w.stream_word[14:0];
                        word_kind  = KIND_LITERAL;
                    end
                end
                KIND_LITERAL:
                begin
                    cells_left = cells_left - 1'b1;
                    if (cells_left == 15'd0)
                        word_kind = KIND_TOKEN;
                    add_fill(w.stream_word, 15'd1, cells_left == 15'd0);
                end
                KIND_RUN_TILE:
                begin
                    word_kind = KIND_TOKEN;
                    if (run_length != 15'd0)
                        add_fill(w.stream_word, run_length, 1'b1);
                end
                default:
                    word_kind = KIND_TOKEN;
            endcase
            return 1'b1;
        endfunction

        function void report(string field, logic [15:0] want, logic [15:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        endfunction

        // Compare a fill item with the oldest prediction
        function void match_fill(fill_item_t got);
            fill_item_t want;
            if (pending_fills.size() == 0) begin
                errors++;
                $display("%0t: fill item with none expected, actual %p", $time, got);
                return;
            end
            want = pending_fills.pop_front();
            if (got.tile_word !== want.tile_word)
                report("tile_word", want.tile_word, got.tile_word);
            if (got.map_row !== want.map_row)
                report("map_row", 16'(want.map_row), 16'(got.map_row));
            if (got.first_column !== want.first_column)
                report("first_column", want.first_column, got.first_column);
            if (got.cell_count !== want.cell_count)
                report("cell_count", 16'(want.cell_count), 16'(got.cell_count));
            if (got.overshoot !== want.overshoot)
                report("overshoot", 16'(want.overshoot), 16'(got.overshoot));
            if (got.map_done !== want.map_done)
                report("map_done", 16'(want.map_done), 16'(got.map_done));
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   word_valid;
    logic                   word_ready;
    word_item_t             word;
    logic                   fill_valid;
    logic                   fill_ready;
    fill_item_t             fill;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    fill_predictor sb = new();

    int send_gap_pct  = 0;
    int recv_gap_pct  = 0;
    int live_items    = 0;
    int quiet_cycles  = 0;
    bit fresh_next    = 1'b0;
    bit hold_request  = 1'b0;

    tile_map_rle_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .word_ready (word_ready),
        .word       (word),
        .fill_valid (fill_valid),
        .fill_ready (fill_ready),
        .fill       (fill),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Offer one stream word, idling first at random, and hold it until accepted
    task automatic send_word(logic [15:0] value);
        word_item_t w;
        w.stream_word = value;
        w.new_map     = fresh_next;
        fresh_next    = 1'b0;
        if ($urandom_range(1, 100) <= send_gap_pct) begin
            word_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        word_valid <= 1'b1;
        word       <= w;
        do @(posedge clk); while (!word_ready);
        if (sb.take_word(w))
            live_items++;
    endtask

    task automatic send_run(logic [14:0] len, logic [15:0] tile);
        send_word({1'b1, len});
        send_word(tile);
    endtask

    task automatic send_literals(int n);
        send_word(16'(n));
        repeat (n) send_word(16'($urandom));
    endtask

    // Run length that brings the row budget back to zero, or a step towards it
    function automatic logic [14:0] row_fit();
        if (sb.column_budget == 16'd0)
            return 15'($urandom_range(1, 600));
        if (sb.column_budget[15])
            return 15'h7FFF;
        return sb.column_budget[14:0];
    endfunction

    // One well-formed token sequence, or a little noise
    task automatic random_sequence();
        int pick;
        pick = $urandom_range(0, 99);
        // after the map is done: ignored words, then a fresh map
        if (sb.finished) begin
            if (pick < 40)
                send_word(16'($urandom));
            else begin
                fresh_next = 1'b1;
                if (pick < 70)
                    send_run((sb.column_count == 0) ? 15'd1 : 15'(sb.column_count),
                             16'($urandom));
                else
                    send_literals($urandom_range(1, 4));
            end
            return;
        end
        // resync after noise left a token half taken
        if (sb.word_kind == KIND_RUN_TILE) begin
            send_word(16'($urandom));
            return;
        end
        if (sb.word_kind == KIND_LITERAL) begin
            if (sb.cells_left > 15'd8) begin
                fresh_next = 1'b1;
                send_word(16'h0000);
            end
            else
                repeat (int'(sb.cells_left)) send_word(16'($urandom));
            return;
        end
        if (pick < 2)
            fresh_next = 1'b1;
        if (pick < 35)
            send_run(row_fit(), 16'($urandom));
        else if (pick < 55)
            send_run(15'($urandom_range(1, 64)), 16'($urandom));
        else if (pick < 60)
            send_run(15'($urandom_range(0, 32767)), 16'($urandom));
        else if (pick < 75) begin
            if (sb.column_budget >= 16'd1 && sb.column_budget <= 16'd8)
                send_literals(int'(sb.column_budget));
            else
                send_literals($urandom_range(1, 6));
        end
        else if (pick < 90)
            send_literals($urandom_range(1, 6));
        else if (pick < 93)
            send_word(16'h0000);
        else
            send_word(16'($urandom));
    endtask

    task automatic run_phase(int target);
        int start;
        start = live_items;
        while (live_items - start < target)
            random_sequence();
    endtask

    // Stop offering words and let every expected fill arrive
    task automatic drain();
        word_valid <= 1'b0;
        while (sb.pending_fills.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(index, data);
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] columns, logic [CFG_DATA_W-1:0] rows);
        write_reg(REG_COLUMN_COUNT, columns);
        write_reg(REG_ROW_COUNT, rows);
        cfg_valid <= 1'b0;
        fresh_next = 1'($urandom_range(0, 1));
    endtask

    // Receiver: random stalls, and a long hold when asked
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        fill_ready <= 1'b1;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                fill_ready <= 1'b0;
            end
            else if (stall_left > 0) begin
                stall_left--;
                fill_ready <= 1'b0;
            end
            else if ($urandom_range(1, 100) <= recv_gap_pct) begin
                stall_left = $urandom_range(0, 15);
                fill_ready <= 1'b0;
            end
            else
                fill_ready <= 1'b1;
        end
    end

    // Check fills and count cycles with no item moving
    always @(posedge clk)
    begin
        if (!rst_n || (word_valid && word_ready) || (fill_valid && fill_ready)
                || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (rst_n && fill_valid && fill_ready)
            sb.match_fill(fill);
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        rst_n      <= 1'b0;
        word_valid <= 1'b0;
        word       <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset configuration
        fresh_next = 1'b1;
        send_word(16'h0000);                // empty literal token
        send_run(15'd0, 16'hABCD);          // empty run still takes its tile
        send_literals(2);
        send_run(row_fit(), 16'hFFFF);      // close the row exactly
        send_run(15'h7FFF, 16'h0000);       // longest run, overshoots
        while (sb.column_position != 16'd0)
            send_run(row_fit(), 16'h8001);  // wrap the budget back to zero
        send_word(16'h7FFF);                // longest literal token, then abandon it
        send_word(16'h5555);
        send_word(16'hAAAA);
        fresh_next = 1'b1;
        send_word(16'h0001);
        send_word(16'h8000);                // literal tile with the top bit set
        drain();

        // Widest rows, tallest map, upper data bits dropped
        send_gap_pct = 30;
        recv_gap_pct = 25;
        configure(16'hFFFF, 16'hFF40);
        run_phase(100);
        drain();

        // Zero columns and zero rows; long output hold with the sender busy
        send_gap_pct = 0;
        recv_gap_pct = 0;
        configure(16'h0000, 16'h0000);
        run_phase(30);
        hold_request = 1'b1;
        run_phase(70);
        drain();

        // Single column, row count beyond the map limit
        send_gap_pct = 10;
        recv_gap_pct = 10;
        configure(16'h0001, 16'h007F);
        run_phase(100);
        drain();

        // Random setting and writes to unused indexes
        send_gap_pct = 40;
        recv_gap_pct = 40;
        write_reg(CFG_INDEX_W'($urandom_range(2, 15)), 16'($urandom));
        write_reg(CFG_INDEX_W'($urandom_range(2, 15)), 16'($urandom));
        configure({4'($urandom), 12'($urandom_range(1, 4095))},
                  {9'($urandom), 7'($urandom_range(0, 127))});
        run_phase(100);
        drain();

        // Short rows, no idling on either side
        send_gap_pct = 0;
        recv_gap_pct = 0;
        configure(16'($urandom_range(1, 40)), 16'($urandom_range(1, 8)));
        run_phase(100);
        drain();

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/tmrle_pkg.sv
rtl/core/tmrle_front.sv
rtl/core/tmrle_queue.sv
rtl/core/tmrle_back.sv
rtl/core/tile_map_rle_decoder.sv
bench/tb_tile_map_rle_decoder.sv
